### hdl/bps_pkg.sv
// Shared types and constants for the beep pattern sequencer.
package bps_pkg;

   // Default depth of the play command queue.
   localparam int QUEUE_DEPTH_DEF = 4;

   // Depth of the item queue between the front and back ends.
   localparam int TQ_DEPTH = 2;
   localparam int TQ_PTR_W = (TQ_DEPTH > 1) ? $clog2(TQ_DEPTH) : 1;
   localparam int TQ_CNT_W = $clog2(TQ_DEPTH + 1);

   // Item kinds carried in the action field.
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_PLAY = 1'b1;

   // One input item as it arrives on the request channel.
   typedef struct packed {
      logic        action;
      logic [15:0] on_time;
      logic [7:0]  repeat_count;
      logic [15:0] gap_time;
   } req_type;

   // One result item on the response channel.
   typedef struct packed {
      logic       buzzer_on;
      logic       accepted;
      logic [2:0] queued;
      logic       busy_res;
   } rsp_type;

   // One stored play command.
   typedef struct packed {
      logic [15:0] on_time;
      logic [7:0]  repeat_count;
      logic [15:0] gap_time;
   } cmd_type;

   // A classified item waiting for the back end.
   typedef struct packed {
      logic    is_play;
      cmd_type cmd;
   } item_type;

   // Head of the item queue as seen by the back end.
   typedef struct packed {
      logic     valid;
      item_type item;
   } task_type;

   // Operations requested of the command queue.
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_op_type;

   // Sequencer phases; the spare code behaves as idle.
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ON   = 2'd1,
      PH_GAP  = 2'd2
   } phase_type;

endpackage

### hdl/bps_ram.sv
// Generic single-port-write, registered-read RAM.
module bps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read of the address being written returns old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bps_front.sv
// Front end: accepts request items, classifies them and queues them for the back end.
module bps_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bps_pkg::req_type  req_payload,
   output bps_pkg::task_type task_out,
   input  logic              task_take
);

   import bps_pkg::*;

   item_type              q_ff [TQ_DEPTH];
   logic [TQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [TQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [TQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                  accept;
   item_type              item_new;

   // A transfer is taken whenever the small queue has a free slot.
   assign req_stall = (cnt_ff == TQ_CNT_W'(TQ_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Classify the item: play commands carry a payload, ticks only advance time.
   always_comb begin
      item_new.is_play          = (req_payload.action == ACT_PLAY);
      item_new.cmd.on_time      = req_payload.on_time;
      item_new.cmd.repeat_count = req_payload.repeat_count;
      item_new.cmd.gap_time     = req_payload.gap_time;
   end

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == TQ_PTR_W'(TQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (task_take) begin
         rd_ptr_in = (rd_ptr_ff == TQ_PTR_W'(TQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !task_take) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!accept && task_take) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= item_new;
      end
   end

   assign task_out.valid = (cnt_ff != '0);
   assign task_out.item  = q_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   a_tq_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= TQ_CNT_W'(TQ_DEPTH))
      else $error("item queue occupancy beyond its depth");
`endif

endmodule

### hdl/bps_cmd_fifo.sv
// Play command queue: RAM storage with a registered head entry for same-cycle access.
module bps_cmd_fifo #(
   parameter int QUEUE_DEPTH = bps_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bps_pkg::fifo_op_type                 op,
   input  bps_pkg::cmd_type                     push_cmd,
   output bps_pkg::cmd_type                     head_cmd,
   output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   count,
   output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   count_next
);

   import bps_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [PTR_W-1:0] head_ptr_ff, head_ptr_in;
   logic [PTR_W-1:0] tail_ptr_ff, tail_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type          head_cmd_ff, head_cmd_in;
   logic             byp_ff, byp_in;
   cmd_type          byp_cmd_ff;
   logic [PTR_W-1:0] rd_addr;
   cmd_type          rd_data;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // The RAM keeps fetching the entry behind the head, so a pop can refill the head at once.
   assign rd_addr = ptr_inc(head_ptr_in);

   // A write to the entry being fetched is not seen by the RAM read; forward it for one cycle.
   assign byp_in = op.push && (tail_ptr_ff == rd_addr);

   always_comb begin
      head_ptr_in = head_ptr_ff;
      tail_ptr_in = tail_ptr_ff;
      count_in    = count_ff;
      head_cmd_in = head_cmd_ff;
      if (op.push) begin
         tail_ptr_in = ptr_inc(tail_ptr_ff);
         count_in    = count_ff + 1'b1;
         if (count_ff == '0) begin
            head_cmd_in = push_cmd;
         end
      end else if (op.pop) begin
         head_ptr_in = ptr_inc(head_ptr_ff);
         count_in    = count_ff - 1'b1;
         if (count_ff > CNT_W'(1)) begin
            head_cmd_in = byp_ff ? byp_cmd_ff : rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff <= '0;
         tail_ptr_ff <= '0;
         count_ff    <= '0;
         byp_ff      <= 1'b0;
      end else begin
         head_ptr_ff <= head_ptr_in;
         tail_ptr_ff <= tail_ptr_in;
         count_ff    <= count_in;
         byp_ff      <= byp_in;
      end
   end

   // Payload copies need no reset.
   always_ff @(posedge clock) begin
      head_cmd_ff <= head_cmd_in;
      byp_cmd_ff  <= push_cmd;
   end

   bps_ram #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (op.push),
      .wr_addr (tail_ptr_ff),
      .wr_data (push_cmd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign head_cmd   = head_cmd_ff;
   assign count      = count_ff;
   assign count_next = count_in;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("command queue occupancy beyond its depth");
   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(op.push && op.pop))
      else $error("command queue pushed and popped in one cycle");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      op.pop |-> count_ff != '0)
      else $error("command queue popped while empty");
`endif

endmodule

### hdl/bps_back.sv
// Back end: runs the beep sequencer on queued items and registers one result per item.
module bps_back #(
   parameter int QUEUE_DEPTH = bps_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  bps_pkg::task_type task_in,
   output logic              task_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bps_pkg::rsp_type  rsp_payload
);

   import bps_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   phase_type        phase_ff, phase_in;
   logic [15:0]      ticks_ff, ticks_in;
   logic [7:0]       beeps_ff, beeps_in;
   logic [15:0]      cur_on_ff, cur_on_in;
   logic [15:0]      cur_gap_ff, cur_gap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   fifo_op_type      fifo_op;
   cmd_type          head_cmd;
   logic [CNT_W-1:0] fifo_count;
   logic [CNT_W-1:0] fifo_count_next;
   logic [CNT_W+2:0] cnt_ext;
   logic             is_tick;
   logic             idle_now;

   // An item is executed whenever the output register is free or being emptied.
   assign task_take = task_in.valid && (!rsp_valid_ff || !rsp_stall);
   assign is_tick   = task_take && !task_in.item.is_play;
   assign idle_now  = (phase_ff != PH_ON) && (phase_ff != PH_GAP);

   // Command queue operations for this item.
   always_comb begin
      fifo_op.push = task_take && task_in.item.is_play &&
                     (fifo_count != CNT_W'(QUEUE_DEPTH));
      fifo_op.pop  = is_tick && idle_now && (fifo_count != '0);
   end

   // Next state: a tick walks through any zero-length phases within the same cycle.
   always_comb begin
      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      beeps_in   = beeps_ff;
      cur_on_in  = cur_on_ff;
      cur_gap_in = cur_gap_ff;
      if (is_tick) begin
         unique case (phase_ff)
            PH_ON: begin
               priority if (ticks_ff > 16'd1) begin
                  ticks_in = ticks_ff - 16'd1;
               end else if (beeps_ff <= 8'd1) begin
                  phase_in = PH_IDLE;
                  ticks_in = '0;
                  beeps_in = '0;
               end else if (cur_gap_ff != '0) begin
                  phase_in = PH_GAP;
                  ticks_in = cur_gap_ff;
                  beeps_in = beeps_ff - 8'd1;
               end else if (cur_on_ff != '0) begin
                  phase_in = PH_ON;
                  ticks_in = cur_on_ff;
                  beeps_in = beeps_ff - 8'd1;
               end else begin
                  phase_in = PH_IDLE;
                  ticks_in = '0;
                  beeps_in = '0;
               end
            end
            PH_GAP: begin
               priority if (ticks_ff > 16'd1) begin
                  ticks_in = ticks_ff - 16'd1;
               end else if (cur_on_ff != '0) begin
                  phase_in = PH_ON;
                  ticks_in = cur_on_ff;
               end else if (beeps_ff <= 8'd1) begin
                  phase_in = PH_IDLE;
                  ticks_in = '0;
                  beeps_in = '0;
               end else if (cur_gap_ff != '0) begin
                  phase_in = PH_GAP;
                  ticks_in = cur_gap_ff;
                  beeps_in = beeps_ff - 8'd1;
               end else begin
                  phase_in = PH_IDLE;
                  ticks_in = '0;
                  beeps_in = '0;
               end
            end
            default: begin
               // Idle, or the spare code: start the oldest command if there is one.
               phase_in = PH_IDLE;
               if (fifo_count != '0) begin
                  cur_on_in  = head_cmd.on_time;
                  cur_gap_in = head_cmd.gap_time;
                  beeps_in   = head_cmd.repeat_count;
                  priority if (head_cmd.repeat_count == '0) begin
                     phase_in = PH_IDLE;
                  end else if (head_cmd.on_time != '0) begin
                     phase_in = PH_ON;
                     ticks_in = head_cmd.on_time;
                  end else if (head_cmd.repeat_count == 8'd1) begin
                     ticks_in = '0;
                     beeps_in = '0;
                  end else if (head_cmd.gap_time != '0) begin
                     phase_in = PH_GAP;
                     ticks_in = head_cmd.gap_time;
                     beeps_in = head_cmd.repeat_count - 8'd1;
                  end else begin
                     ticks_in = '0;
                     beeps_in = '0;
                  end
               end
            end
         endcase
      end
   end

   // Result fields follow the state after this item; the count is shown modulo eight.
   assign cnt_ext = {3'b000, fifo_count_next};

   always_comb begin
      rsp_in.buzzer_on = (phase_in == PH_ON);
      rsp_in.accepted  = fifo_op.push;
      rsp_in.queued    = cnt_ext[2:0];
      rsp_in.busy_res  = (phase_in == PH_ON) || (phase_in == PH_GAP);
      rsp_valid_in     = task_take || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         ticks_ff     <= '0;
         beeps_ff     <= '0;
         cur_on_ff    <= '0;
         cur_gap_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         ticks_ff     <= ticks_in;
         beeps_ff     <= beeps_in;
         cur_on_ff    <= cur_on_in;
         cur_gap_ff   <= cur_gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register holds while the receiver stalls.
   always_ff @(posedge clock) begin
      if (task_take) begin
         rsp_ff <= rsp_in;
      end
   end

   bps_cmd_fifo #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .op         (fifo_op),
      .push_cmd   (task_in.item.cmd),
      .head_cmd   (head_cmd),
      .count      (fifo_count),
      .count_next (fifo_count_next)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_active_counts: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ON || phase_ff == PH_GAP) |-> (ticks_ff != '0 && beeps_ff != '0))
      else $error("active phase with an exhausted tick or beep count");
   a_buzz_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.buzzer_on) |-> rsp_ff.busy_res)
      else $error("buzzer reported on while not busy");
`endif

endmodule

### hdl/beep_pattern_sequencer.sv
// Top level of the beep pattern sequencer.
//
// Request channel (req_valid, req_stall, req_payload): each transfer is either a
// one-millisecond tick (action 0) or a play command (action 1) carrying on-time,
// repeat count and gap time. Play commands go into a QUEUE_DEPTH-entry command
// queue and are refused at once, with accepted = 0, when it is full.
// Response channel (rsp_valid, rsp_stall, rsp_payload): exactly one transfer per
// request, in order, giving the buzzer level, accepted flag, queue fill and busy.
//
// Throughput is one item per clock cycle while rsp_stall is low; the sequencer
// state and command queue update once per item and the head command sits in a
// register, so a tick can start a command in the same cycle. An item enters a
// two-entry item queue, then the back end executes it into the output register.
// When rsp_stall is high the result register holds, the item queue fills and
// req_stall rises once both of its entries are taken.
// Reset clears the queues and leaves the sequencer idle and silent; no clearing
// pass is needed.
module beep_pattern_sequencer #(
   parameter int QUEUE_DEPTH = bps_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bps_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bps_pkg::rsp_type rsp_payload
);

   import bps_pkg::*;

   task_type task_bus;
   logic     task_take;

   // Front end: accept and classify.
   bps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .task_out    (task_bus),
      .task_take   (task_take)
   );

   // Back end: sequencer, command queue and result register.
   bps_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .task_in     (task_bus),
      .task_take   (task_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
